/* design/bbc_pkg.sv */
`default_nettype none

package bbc_pkg;

    // command codes
    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_ZEROREL = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] device;
        logic [7:0] block;
        logic [2:0] slot;
    } in_word_t;

    typedef struct packed {
        logic [2:0] slot_out;
        logic       hit;
        logic       needs_read;
        logic [1:0] status;
    } out_word_t;

    // one slot's bookkeeping record
    typedef struct packed {
        logic        present;
        logic [7:0]  device;
        logic [7:0]  block;
        logic [15:0] count;
        logic        valid;
    } slot_rec_t;

endpackage

`default_nettype wire

/* design/bbc_slot_mem.sv */
`default_nettype none

// Slot record store. Per-entry written bits make unwritten entries read as all zero.
module bbc_slot_mem #(
    parameter int NUM_SLOTS = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [$clog2(NUM_SLOTS)-1:0]  raddr,
    output bbc_pkg::slot_rec_t            rdata,
    input  wire                           we,
    input  wire  [$clog2(NUM_SLOTS)-1:0]  waddr,
    input  bbc_pkg::slot_rec_t            wdata
);

    bbc_pkg::slot_rec_t mem [NUM_SLOTS];
    bbc_pkg::slot_rec_t rd_reg;
    logic [NUM_SLOTS-1:0] vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[raddr];
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

/* design/bbc_order_mem.sv */
`default_nettype none

// Recency order store: position -> slot. An unwritten position reads as its own index.
module bbc_order_mem #(
    parameter int NUM_SLOTS = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [$clog2(NUM_SLOTS)-1:0]  raddr,
    output logic [$clog2(NUM_SLOTS)-1:0]  rdata,
    input  wire                           we,
    input  wire  [$clog2(NUM_SLOTS)-1:0]  waddr,
    input  wire  [$clog2(NUM_SLOTS)-1:0]  wdata
);

    localparam int SW = $clog2(NUM_SLOTS);

    logic [SW-1:0]        mem [NUM_SLOTS];
    logic [SW-1:0]        rd_reg;
    logic [SW-1:0]        rd_addr_reg;
    logic [NUM_SLOTS-1:0] vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg      <= mem[raddr];
        rd_addr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[raddr];
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : rd_addr_reg;

endmodule

`default_nettype wire

/* design/block_buffer_cache_lru.sv */
`default_nettype none

// Tag and replacement manager for a small block buffer cache of NUM_SLOTS slots.
// A command word is taken when start is high and busy is low; each command gives
// exactly one result word, shown on result for one cycle with done high. The
// receiver cannot stall, so it must take every result on the cycle it appears.
// A get walks the whole recency order through the order store and the slot
// store back to back. A write or a release reads the slot record back before it
// reports. A release that drops a count to zero reports, but stays busy while
// the slot is moved to most recent, one position per cycle. Writes and releases
// with an out-of-range slot, and unknown commands, report on the next cycle.
// Commands 0 get, 1 write (mark valid), 2 release; status 0 ok, 1 no free
// buffer, 2 release with zero count.
module block_buffer_cache_lru #(
    parameter int NUM_SLOTS = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  bbc_pkg::in_word_t   item,
    output logic                busy,
    output logic                done,
    output bbc_pkg::out_word_t  result
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,   // get: scan recency order
        S_RMW   = 4'b0100,   // write / release: record read back
        S_SHIFT = 4'b1000    // release to zero: move slot to most recent
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [CW-1:0] iss_reg, iss_next;       // next order position to read
    logic          v1_reg, v1_next;         // order read data valid
    logic          v2_reg, v2_next;         // slot record valid
    logic          found_reg, found_next;
    logic          free_reg, free_next;
    logic          rel_reg, rel_next;
    logic          done_reg, done_next;

    // payload
    logic [7:0]          dev_reg, dev_next;
    logic [7:0]          blk_reg, blk_next;
    logic [SW-1:0]       sl_reg, sl_next;
    logic [SW-1:0]       s2_reg, s2_next;
    logic [SW-1:0]       fslot_reg, fslot_next;
    bbc_pkg::slot_rec_t  frec_reg, frec_next;
    logic [SW-1:0]       free_slot_reg, free_slot_next;
    logic [SW-1:0]       wpos_reg, wpos_next;
    logic [SW-1:0]       carry_reg, carry_next;
    bbc_pkg::out_word_t  result_reg, result_next;

    // memory ports
    logic [SW-1:0]       slot_raddr, slot_waddr;
    logic                slot_we;
    bbc_pkg::slot_rec_t  slot_rdata, slot_wdata;
    logic [SW-1:0]       order_raddr, order_waddr, order_wdata, order_rdata;
    logic                order_we;

    // decode helpers
    logic [SW+2:0]       item_ext;
    logic [SW-1:0]       item_idx;
    logic                in_range;
    bbc_pkg::slot_rec_t  rec;
    logic                match_now, free_now, hit_any, free_any, iss_more;
    logic [SW-1:0]       hit_slot, free_sel;
    bbc_pkg::slot_rec_t  hit_rec;

    function automatic logic [2:0] idx3(input logic [SW-1:0] i);
        logic [SW+2:0] w;
        w = {3'b000, i};
        return w[2:0];
    endfunction

    bbc_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (slot_raddr),
        .rdata (slot_rdata),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata)
    );

    bbc_order_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_order_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (order_raddr),
        .rdata (order_rdata),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata)
    );

    assign item_ext = {{SW{1'b0}}, item.slot};
    assign item_idx = item_ext[SW-1:0];
    assign in_range = 32'(item.slot) < NUM_SLOTS;

    // scan evaluation: first tag match from most recent wins, last zero count
    // seen (nearest least recent end) is the replacement victim
    assign rec       = slot_rdata;
    assign match_now = v2_reg && rec.present && (rec.device == dev_reg)
                       && (rec.block == blk_reg);
    assign free_now  = v2_reg && (rec.count == 16'd0);
    assign hit_any   = found_reg || match_now;
    assign hit_slot  = found_reg ? fslot_reg : s2_reg;
    assign hit_rec   = found_reg ? frec_reg : rec;
    assign free_any  = free_now || free_reg;
    assign free_sel  = free_now ? s2_reg : free_slot_reg;
    assign iss_more  = iss_reg < CW'(NUM_SLOTS);

    assign order_raddr = (state_reg == S_IDLE) ? '0 : iss_reg[SW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        rel_next       = rel_reg;
        done_next      = 1'b0;
        dev_next       = dev_reg;
        blk_next       = blk_reg;
        sl_next        = sl_reg;
        s2_next        = s2_reg;
        fslot_next     = fslot_reg;
        frec_next      = frec_reg;
        free_slot_next = free_slot_reg;
        wpos_next      = wpos_reg;
        carry_next     = carry_reg;
        result_next    = result_reg;

        slot_raddr  = '0;
        slot_we     = 1'b0;
        slot_waddr  = sl_reg;
        slot_wdata  = rec;
        order_we    = 1'b0;
        order_waddr = wpos_reg;
        order_wdata = carry_reg;

        case (state_reg)
            S_IDLE:
            begin
                slot_raddr = item_idx;
                if (start)
                begin
                    sl_next    = item_idx;
                    dev_next   = item.device;
                    blk_next   = item.block;
                    rel_next   = (item.command == bbc_pkg::CMD_RELEASE);
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    v2_next    = 1'b0;
                    case (item.command)
                        bbc_pkg::CMD_GET:
                        begin
                            iss_next   = CW'(1);
                            v1_next    = 1'b1;
                            state_next = S_WALK;
                        end
                        bbc_pkg::CMD_WRITE, bbc_pkg::CMD_RELEASE:
                        begin
                            if (in_range)
                            begin
                                iss_next   = '0;
                                state_next = S_RMW;
                            end
                            else
                            begin
                                done_next              = 1'b1;
                                result_next.slot_out   = item.slot;
                                result_next.hit        = 1'b0;
                                result_next.needs_read = 1'b0;
                                result_next.status     = bbc_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            done_next              = 1'b1;
                            result_next.slot_out   = 3'd0;
                            result_next.hit        = 1'b0;
                            result_next.needs_read = 1'b0;
                            result_next.status     = bbc_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                slot_raddr = order_rdata;
                v2_next    = v1_reg;
                s2_next    = order_rdata;
                v1_next    = iss_more;
                if (iss_more)
                begin
                    iss_next = iss_reg + CW'(1);
                end
                if (match_now && !found_reg)
                begin
                    found_next = 1'b1;
                    fslot_next = s2_reg;
                    frec_next  = rec;
                end
                if (free_now)
                begin
                    free_next      = 1'b1;
                    free_slot_next = s2_reg;
                end
                if (v2_reg && !v1_reg)
                begin
                    state_next = S_IDLE;
                    v1_next    = 1'b0;
                    v2_next    = 1'b0;
                    done_next  = 1'b1;
                    if (hit_any)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = hit_slot;
                        slot_wdata = hit_rec;
                        if (hit_rec.count != bbc_pkg::COUNT_MAX)
                        begin
                            slot_wdata.count = hit_rec.count + 16'd1;
                        end
                        result_next.slot_out   = idx3(hit_slot);
                        result_next.hit        = 1'b1;
                        result_next.needs_read = !hit_rec.valid;
                        result_next.status     = bbc_pkg::ST_OK;
                    end
                    else if (free_any)
                    begin
                        slot_we            = 1'b1;
                        slot_waddr         = free_sel;
                        slot_wdata.present = 1'b1;
                        slot_wdata.device  = dev_reg;
                        slot_wdata.block   = blk_reg;
                        slot_wdata.count   = 16'd1;
                        slot_wdata.valid   = 1'b0;
                        result_next.slot_out   = idx3(free_sel);
                        result_next.hit        = 1'b0;
                        result_next.needs_read = 1'b1;
                        result_next.status     = bbc_pkg::ST_OK;
                    end
                    else
                    begin
                        result_next.slot_out   = 3'd0;
                        result_next.hit        = 1'b0;
                        result_next.needs_read = 1'b0;
                        result_next.status     = bbc_pkg::ST_NOFREE;
                    end
                end
            end

            S_RMW:
            begin
                state_next             = S_IDLE;
                done_next              = 1'b1;
                result_next.slot_out   = idx3(sl_reg);
                result_next.hit        = 1'b0;
                result_next.needs_read = 1'b0;
                result_next.status     = bbc_pkg::ST_OK;
                if (!rel_reg)
                begin
                    slot_we          = 1'b1;
                    slot_wdata.valid = 1'b1;
                end
                else if (rec.count == 16'd0)
                begin
                    result_next.status = bbc_pkg::ST_ZEROREL;
                end
                else
                begin
                    slot_we          = 1'b1;
                    slot_wdata.count = rec.count - 16'd1;
                    if (rec.count == 16'd1)
                    begin
                        // order read of position 0 is issued this cycle
                        state_next = S_SHIFT;
                        iss_next   = CW'(1);
                        v1_next    = 1'b1;
                        wpos_next  = '0;
                        carry_next = sl_reg;
                    end
                end
            end

            S_SHIFT:
            begin
                // ripple the slot in from the front until its old position
                if (v1_reg)
                begin
                    order_we   = 1'b1;
                    carry_next = order_rdata;
                    if (order_rdata == sl_reg)
                    begin
                        state_next = S_IDLE;
                        v1_next    = 1'b0;
                    end
                    else
                    begin
                        wpos_next = wpos_reg + SW'(1);
                        v1_next   = iss_more;
                        if (iss_more)
                        begin
                            iss_next = iss_reg + CW'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iss_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            rel_reg   <= rel_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg       <= dev_next;
        blk_reg       <= blk_next;
        sl_reg        <= sl_next;
        s2_reg        <= s2_next;
        fslot_reg     <= fslot_next;
        frec_reg      <= frec_next;
        free_slot_reg <= free_slot_next;
        wpos_reg      <= wpos_next;
        carry_reg     <= carry_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // every accepted word either reports at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither reported nor in progress");

    // a hit is always a clean status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.status == bbc_pkg::ST_OK))
        else $error("hit reported with error status");

    // order shift never writes the position being read
    a_order_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        order_we |-> (order_waddr != order_raddr))
        else $error("order store read and write collide");

    // record write-backs are single cycle, never back to back
    a_slot_we_single: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |=> !slot_we)
        else $error("back-to-back slot record writes");

    // no free buffer reports a zero slot and no read request
    a_nofree_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == bbc_pkg::ST_NOFREE))
            |-> ((result.slot_out == 3'd0) && !result.needs_read))
        else $error("no-free result carries stray fields");

endmodule

`default_nettype wire
